// ===== src/lcp_pkg.sv =====
package lcp_pkg;

    localparam int FRAC_BITS = 12;
    localparam int ONE_Q12   = 4096;
    localparam int UW        = 17;
    localparam int T_FULL    = 65536;
    localparam int GW        = 13;
    localparam int ZW        = 13;

    localparam logic [1:0] REG_FORGET_BIAS    = 2'd0;
    localparam logic [1:0] REG_ZONEOUT_CELL   = 2'd1;
    localparam logic [1:0] REG_ZONEOUT_HIDDEN = 2'd2;

endpackage

// ===== src/lcp_act.sv =====
module lcp_act
    import lcp_pkg::*;
#(
    parameter int ACT_SEGMENTS = 32
) (
    input  logic          i_clk,
    input  logic [UW-1:0] i_u,
    output logic [UW-1:0] o_y
);

    localparam int SEG = ACT_SEGMENTS;
    localparam int SB  = (SEG > 1) ? $clog2(SEG) : 1;
    localparam int MW  = 6;
    localparam int RK  = 28;
    localparam int RW  = RK + 1;
    localparam int DUW = 13;
    localparam int XW  = UW + DUW;
    localparam int ZBW = 22;
    localparam int QW  = 23;
    localparam logic [63:0] EXP_STEP = 64'd4034748382;

    function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b}) begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic int unsigned knot_n(input int unsigned k);
        return 32'(udiv(64'(k) * 64'd256, 64'(SEG)));
    endfunction

    function automatic logic [UW-1:0] knot_value(input int unsigned n);
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        e = 64'd1 << 32;
        for (int unsigned i = 0; i < n; i++) begin
            e = (e * EXP_STEP) >> 32;
        end
        num = ((64'd1 << 32) - e) << 16;
        den = (64'd1 << 32) + e;
        return UW'(udiv(num + (den >> 1), den));
    endfunction

    function automatic logic [SEG*UW-1:0] build_y0();
        logic [SEG*UW-1:0] tab;
        tab = '0;
        for (int s = 0; s < SEG; s++) begin
            tab[s*UW +: UW] = knot_value(knot_n(s));
        end
        return tab;
    endfunction

    function automatic logic [SEG*UW-1:0] build_dy();
        logic [SEG*UW-1:0] tab;
        tab = '0;
        for (int s = 0; s < SEG; s++) begin
            tab[s*UW +: UW] = knot_value(knot_n(s + 1))
                            - knot_value(knot_n(s));
        end
        return tab;
    endfunction

    function automatic logic [SEG*UW-1:0] build_u0();
        logic [SEG*UW-1:0] tab;
        tab = '0;
        for (int s = 0; s < SEG; s++) begin
            tab[s*UW +: UW] = UW'(knot_n(s) * 256);
        end
        return tab;
    endfunction

    function automatic logic [SEG*MW-1:0] build_m();
        logic [SEG*MW-1:0] tab;
        tab = '0;
        for (int s = 0; s < SEG; s++) begin
            tab[s*MW +: MW] = MW'(knot_n(s + 1) - knot_n(s));
        end
        return tab;
    endfunction

    function automatic logic [SEG*RW-1:0] build_rc();
        logic [SEG*RW-1:0] tab;
        logic [63:0]       m;
        tab = '0;
        for (int s = 0; s < SEG; s++) begin
            m = 64'(knot_n(s + 1) - knot_n(s));
            tab[s*RW +: RW] = RW'(udiv((64'd1 << RK) + m - 64'd1, m));
        end
        return tab;
    endfunction

    localparam logic [SEG*UW-1:0] Y0_TAB = build_y0();
    localparam logic [SEG*UW-1:0] DY_TAB = build_dy();
    localparam logic [SEG*UW-1:0] U0_TAB = build_u0();
    localparam logic [SEG*MW-1:0] M_TAB  = build_m();
    localparam logic [SEG*RW-1:0] RC_TAB = build_rc();
    localparam logic [UW-1:0]     Y_LAST = knot_value(256);

    logic [UW+8:0]   n_segp;
    logic            n_full;
    logic [SB-1:0]   n_idx;
    logic [UW-1:0]   n_u0;
    logic [DUW-1:0]  n_du;
    logic [ZBW-1:0]  n_z;
    logic [ZBW+RW-1:0] n_qp;
    logic [UW+7:0]   n_sum;
    logic [UW-1:0]   n_y;

    logic [XW-1:0]   r_a_x;
    logic [UW-1:0]   r_a_y0;
    logic [MW-1:0]   r_a_m;
    logic [RW-1:0]   r_a_rc;
    logic            r_a_full;
    logic [QW-1:0]   r_b_q;
    logic [UW-1:0]   r_b_y0;
    logic            r_b_full;
    logic [UW-1:0]   r_y;

    always_comb begin
        n_segp = {9'd0, i_u} * (UW+9)'(SEG);
        n_full = (i_u >= UW'(T_FULL));
        n_idx  = n_full ? '0 : n_segp[16 +: SB];
        n_u0   = U0_TAB[int'(n_idx)*UW +: UW];
        n_du   = DUW'(i_u - n_u0);
        n_z    = ZBW'((r_a_x + (XW'(r_a_m) << 7)) >> 8);
        n_qp   = (ZBW+RW)'(n_z) * (ZBW+RW)'(r_a_rc);
        n_sum  = (UW+8)'(r_b_y0) + (UW+8)'(r_b_q);
        if (r_b_full) begin
            n_y = Y_LAST;
        end else if (n_sum > (UW+8)'(T_FULL)) begin
            n_y = UW'(T_FULL);
        end else begin
            n_y = UW'(n_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_x    <= XW'(DY_TAB[int'(n_idx)*UW +: UW]) * XW'(n_du);
        r_a_y0   <= Y0_TAB[int'(n_idx)*UW +: UW];
        r_a_m    <= M_TAB[int'(n_idx)*MW +: MW];
        r_a_rc   <= RC_TAB[int'(n_idx)*RW +: RW];
        r_a_full <= n_full;
        r_b_q    <= QW'(n_qp >> RK);
        r_b_y0   <= r_a_y0;
        r_b_full <= r_a_full;
        r_y      <= n_y;
    end

    assign o_y = r_y;

endmodule

// ===== src/lstm_cell_pointwise.sv =====
// Pointwise LSTM cell update for one hidden unit per transfer. A new unit is
// taken in every clock cycle (busy never rises) and its result appears on the
// output ports, marked by o_valid for one cycle, after the two activation
// lookups in series, each three stages deep, plus the gate, product, rounding
// and blend stages. The receiver cannot stall, so results must be captured
// when o_valid is high. Configuration writes take effect at once and should
// be made while idle.
module lstm_cell_pointwise
    import lcp_pkg::*;
#(
    parameter int ACT_SEGMENTS = 32,
    parameter int DATA_WIDTH   = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [(DATA_WIDTH > ZW ? DATA_WIDTH : ZW)-1:0] i_cfg_data,
    input  logic signed [DATA_WIDTH-1:0] i_pre_input_gate,
    input  logic signed [DATA_WIDTH-1:0] i_pre_candidate,
    input  logic signed [DATA_WIDTH-1:0] i_pre_forget_gate,
    input  logic signed [DATA_WIDTH-1:0] i_pre_output_gate,
    input  logic signed [DATA_WIDTH-1:0] i_cell_prev,
    input  logic signed [DATA_WIDTH-1:0] i_hidden_prev,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_cell_next,
    output logic signed [DATA_WIDTH-1:0] o_hidden_out,
    output logic signed [DATA_WIDTH-1:0] o_hidden_keep,
    output logic                         o_saturated
);

    localparam int DW  = DATA_WIDTH;
    localparam int WA  = (DW + 2 > 18) ? DW + 2 : 18;
    localparam int PW  = DW + 17;
    localparam int LAT = 16;
    localparam logic signed [PW-1:0] HI = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [PW-1:0] LO = ~HI;

    function automatic logic [UW-1:0] sig_u(input logic signed [WA-1:0] x);
        logic [WA-1:0] mag;
        mag = x[WA-1] ? WA'(-x) : WA'(x);
        return (mag >= WA'(T_FULL)) ? UW'(T_FULL) : UW'(mag);
    endfunction

    function automatic logic [UW-1:0] tanh_u(input logic signed [WA-1:0] x);
        logic [WA-1:0] mag;
        mag = x[WA-1] ? WA'(-x) : WA'(x);
        return (mag >= WA'(T_FULL / 2)) ? UW'(T_FULL) : UW'(mag << 1);
    endfunction

    function automatic logic [GW-1:0] sig_post(input logic [UW-1:0] y, input logic neg);
        logic [UW:0] v;
        v = neg ? ((UW+1)'(T_FULL) - (UW+1)'(y)) : ((UW+1)'(T_FULL) + (UW+1)'(y));
        return GW'((v + (UW+1)'(16)) >> 5);
    endfunction

    function automatic logic signed [GW:0] tanh_post(input logic [UW-1:0] y, input logic neg);
        logic [GW:0] r;
        r = (GW+1)'((y + UW'(8)) >> 4);
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [DW:0] sat_rnd(input logic signed [PW-1:0] x);
        logic signed [PW-1:0] r;
        r = (x + PW'(ONE_Q12 / 2)) >>> FRAC_BITS;
        if (r > HI) begin
            return {1'b1, HI[DW-1:0]};
        end else if (r < LO) begin
            return {1'b1, LO[DW-1:0]};
        end
        return {1'b0, r[DW-1:0]};
    endfunction

    logic signed [DW-1:0] r_fb;
    logic [ZW-1:0]        r_zc;
    logic [ZW-1:0]        r_zh;
    logic [LAT:1]         r_vld;

    logic [UW-1:0]        r_u [0:3];
    logic [UW-1:0]        w_y [0:3];
    logic [3:0]           r_neg [1:4];
    logic signed [DW-1:0] r_cp [1:7];
    logic signed [DW-1:0] r_hp [1:14];
    logic [GW-1:0]        r_gi;
    logic [GW-1:0]        r_gf;
    logic [GW-1:0]        r_go [5:12];
    logic signed [GW:0]   r_gg;
    logic signed [PW-1:0] r_p1;
    logic signed [PW-1:0] r_p2;
    logic signed [DW-1:0] r_c;
    logic [UW-1:0]        r_uc;
    logic [UW-1:0]        w_yc;
    logic                 r_cneg [8:11];
    logic signed [PW-1:0] r_b1;
    logic signed [PW-1:0] r_b2;
    logic signed [DW-1:0] r_cn [9:15];
    logic                 r_fl [7:15];
    logic signed [GW:0]   r_th;
    logic signed [PW-1:0] r_hprod;
    logic signed [DW-1:0] r_h;
    logic signed [DW-1:0] r_h15;
    logic signed [PW-1:0] r_k1;
    logic signed [PW-1:0] r_k2;
    logic signed [DW-1:0] r_o_cn;
    logic signed [DW-1:0] r_o_h;
    logic signed [DW-1:0] r_o_hk;
    logic                 r_o_sat;

    logic                 n_acc;
    logic signed [WA-1:0] n_fsum;
    logic [DW:0]          n_c;
    logic [DW:0]          n_cn;
    logic [DW:0]          n_h;
    logic [DW:0]          n_hk;
    logic signed [ZW:0]   n_wc;
    logic signed [ZW:0]   n_wh;

    assign busy  = 1'b0;
    assign n_acc = start & ~busy;

    always_comb begin
        n_fsum = WA'(i_pre_forget_gate) + WA'(r_fb);
        n_c    = sat_rnd(r_p1 + r_p2);
        n_cn   = sat_rnd(r_b1 + r_b2);
        n_h    = sat_rnd(r_hprod);
        n_hk   = sat_rnd(r_k1 + r_k2);
        n_wc   = $signed((ZW+1)'(ONE_Q12)) - $signed({1'b0, r_zc});
        n_wh   = $signed((ZW+1)'(ONE_Q12)) - $signed({1'b0, r_zh});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb  <= '0;
            r_zc  <= '0;
            r_zh  <= '0;
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-1:1], n_acc};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FORGET_BIAS:    r_fb <= i_cfg_data[DW-1:0];
                    REG_ZONEOUT_CELL:   r_zc <= i_cfg_data[ZW-1:0];
                    REG_ZONEOUT_HIDDEN: r_zh <= i_cfg_data[ZW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_u[0]   <= sig_u(WA'(i_pre_input_gate));
        r_u[1]   <= tanh_u(WA'(i_pre_candidate));
        r_u[2]   <= sig_u(n_fsum);
        r_u[3]   <= sig_u(WA'(i_pre_output_gate));
        r_neg[1] <= {i_pre_output_gate[DW-1], n_fsum[WA-1],
                     i_pre_candidate[DW-1], i_pre_input_gate[DW-1]};
        r_cp[1]  <= i_cell_prev;
        r_hp[1]  <= i_hidden_prev;
        for (int k = 2; k <= 4; k++) begin
            r_neg[k] <= r_neg[k-1];
        end
        for (int k = 2; k <= 7; k++) begin
            r_cp[k] <= r_cp[k-1];
        end
        for (int k = 2; k <= 14; k++) begin
            r_hp[k] <= r_hp[k-1];
        end

        r_gi    <= sig_post(w_y[0], r_neg[4][0]);
        r_gg    <= tanh_post(w_y[1], r_neg[4][1]);
        r_gf    <= sig_post(w_y[2], r_neg[4][2]);
        r_go[5] <= sig_post(w_y[3], r_neg[4][3]);
        for (int k = 6; k <= 12; k++) begin
            r_go[k] <= r_go[k-1];
        end

        r_p1 <= PW'(r_cp[5]) * PW'($signed({1'b0, r_gf}));
        r_p2 <= PW'($signed({1'b0, r_gi})) * PW'(r_gg);

        r_c     <= n_c[DW-1:0];
        r_fl[7] <= n_c[DW];

        r_uc      <= tanh_u(WA'(r_c));
        r_cneg[8] <= r_c[DW-1];
        r_b1      <= PW'(n_wc) * PW'(r_c);
        r_b2      <= PW'($signed({1'b0, r_zc})) * PW'(r_cp[7]);
        r_fl[8]   <= r_fl[7];
        for (int k = 9; k <= 11; k++) begin
            r_cneg[k] <= r_cneg[k-1];
        end

        r_cn[9] <= n_cn[DW-1:0];
        r_fl[9] <= r_fl[8] | n_cn[DW];
        for (int k = 10; k <= 15; k++) begin
            r_cn[k] <= r_cn[k-1];
        end
        for (int k = 10; k <= 13; k++) begin
            r_fl[k] <= r_fl[k-1];
        end

        r_th    <= tanh_post(w_yc, r_cneg[11]);
        r_hprod <= PW'($signed({1'b0, r_go[12]})) * PW'(r_th);

        r_h      <= n_h[DW-1:0];
        r_fl[14] <= r_fl[13] | n_h[DW];

        r_k1     <= PW'(n_wh) * PW'(r_h);
        r_k2     <= PW'($signed({1'b0, r_zh})) * PW'(r_hp[14]);
        r_h15    <= r_h;
        r_fl[15] <= r_fl[14];

        r_o_cn  <= r_cn[15];
        r_o_h   <= r_h15;
        r_o_hk  <= n_hk[DW-1:0];
        r_o_sat <= r_fl[15] | n_hk[DW];
    end

    for (genvar g = 0; g < 4; g++) begin : g_gate
        lcp_act #(
            .ACT_SEGMENTS(ACT_SEGMENTS)
        ) u_act (
            .i_clk(i_clk),
            .i_u  (r_u[g]),
            .o_y  (w_y[g])
        );
    end

    lcp_act #(
        .ACT_SEGMENTS(ACT_SEGMENTS)
    ) u_act_cell (
        .i_clk(i_clk),
        .i_u  (r_uc),
        .o_y  (w_yc)
    );

    assign o_valid       = r_vld[LAT];
    assign o_cell_next   = r_o_cn;
    assign o_hidden_out  = r_o_h;
    assign o_hidden_keep = r_o_hk;
    assign o_saturated   = r_o_sat;

endmodule

// ===== src/lcp_check.sv =====
module lcp_check #(
    parameter int DATA_WIDTH = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_valid,
    input logic signed [DATA_WIDTH-1:0] o_hidden_out
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised although every cycle takes a transfer");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 16))
        else $error("result without a start sixteen cycles earlier");

    a_hidden_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hidden_out <= 4096 && o_hidden_out >= -4096))
        else $error("hidden output beyond the range of o times tanh");

endmodule

bind lstm_cell_pointwise lcp_check #(
    .DATA_WIDTH(DATA_WIDTH)
) u_lcp_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_hidden_out(o_hidden_out)
);

// ===== tb/lstm_cell_checker.sv =====
module lstm_cell_checker
    import lcp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic signed [15:0] i_pre_input_gate,
    input  logic signed [15:0] i_pre_candidate,
    input  logic signed [15:0] i_pre_forget_gate,
    input  logic signed [15:0] i_pre_output_gate,
    input  logic signed [15:0] i_cell_prev,
    input  logic signed [15:0] i_hidden_prev,
    input  logic               o_valid,
    input  logic signed [15:0] o_cell_next,
    input  logic signed [15:0] o_hidden_out,
    input  logic signed [15:0] o_hidden_keep,
    input  logic               o_saturated,
    output int                 o_errors,
    output int                 o_units_checked,
    output int                 o_sat_seen,
    output int                 o_pending
);

    typedef struct packed {
        logic signed [15:0] cell_next;
        logic signed [15:0] hidden_out;
        logic signed [15:0] hidden_keep;
        logic               saturated;
    } t_unit_result;

    localparam int ACT_SEG = 32;

    t_unit_result    expected_units[$];
    longint          knot_y[0:ACT_SEG];
    longint          forget_bias_q;
    longint          zone_cell_w;
    longint          zone_hidden_w;

    function automatic longint knot_at(int n);
        longint unsigned e;
        longint unsigned num;
        longint unsigned den;
        e = 64'd1 << 32;
        for (int i = 0; i < n; i++) begin
            e = (e * 64'd4034748382) >> 32;
        end
        num = ((64'd1 << 32) - e) << 16;
        den = (64'd1 << 32) + e;
        return longint'((num + den / 2) / den);
    endfunction

    initial begin
        for (int k = 0; k <= ACT_SEG; k++) begin
            knot_y[k] = knot_at((k * 256) / ACT_SEG);
        end
    end

    function automatic longint curve(longint u);
        longint s;
        longint n0;
        longint n1;
        longint d;
        longint y;
        if (u >= T_FULL) begin
            return knot_y[ACT_SEG];
        end
        s = (u * ACT_SEG) >>> 16;
        n0 = (s * 256) / ACT_SEG;
        n1 = ((s + 1) * 256) / ACT_SEG;
        d = (n1 - n0) * 256;
        if (d == 0 || knot_y[s + 1] < knot_y[s]) begin
            return knot_y[s];
        end
        y = knot_y[s] + ((knot_y[s + 1] - knot_y[s]) * (u - n0 * 256) + d / 2) / d;
        return (y > T_FULL) ? T_FULL : y;
    endfunction

    function automatic longint tanh_fx(longint x);
        longint m;
        longint r;
        m = (x < 0) ? -x : x;
        r = (curve((m >= T_FULL) ? T_FULL : 2 * m) + 8) >>> 4;
        return (x < 0) ? -r : r;
    endfunction

    function automatic longint sigmoid_fx(longint x);
        longint m;
        longint y;
        m = (x < 0) ? -x : x;
        y = curve((m > T_FULL) ? T_FULL : m);
        return (((x < 0) ? T_FULL - y : T_FULL + y) + 16) >>> 5;
    endfunction

    function automatic longint clip16(longint v, ref logic flag);
        if (v > 32767) begin
            flag = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            flag = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic t_unit_result compute_unit(longint pi, longint pg, longint pf,
                                                  longint po, longint cp, longint hp);
        t_unit_result r;
        logic   flag;
        longint c;
        longint h;
        flag = 1'b0;
        c = clip16((cp * sigmoid_fx(pf + forget_bias_q) + sigmoid_fx(pi) * tanh_fx(pg)
                    + 2048) >>> FRAC_BITS, flag);
        h = clip16((sigmoid_fx(po) * tanh_fx(c) + 2048) >>> FRAC_BITS, flag);
        r.cell_next = 16'(clip16(((ONE_Q12 - zone_cell_w) * c + zone_cell_w * cp + 2048)
                                 >>> FRAC_BITS, flag));
        r.hidden_out = 16'(h);
        r.hidden_keep = 16'(clip16(((ONE_Q12 - zone_hidden_w) * h + zone_hidden_w * hp
                                    + 2048) >>> FRAC_BITS, flag));
        r.saturated = flag;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_units_checked = 0;
        o_sat_seen = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_unit_result want;
        if (!i_rst_n) begin
            forget_bias_q <= 0;
            zone_cell_w <= 0;
            zone_hidden_w <= 0;
        end else begin
            if (o_valid) begin
                if (expected_units.size() == 0) begin
                    report_mismatch("unexpected result transfer", 1, 0);
                end else begin
                    want = expected_units.pop_front();
                    if (o_cell_next !== want.cell_next)
                        report_mismatch("cell_next", o_cell_next, want.cell_next);
                    if (o_hidden_out !== want.hidden_out)
                        report_mismatch("hidden_out", o_hidden_out, want.hidden_out);
                    if (o_hidden_keep !== want.hidden_keep)
                        report_mismatch("hidden_keep", o_hidden_keep, want.hidden_keep);
                    if (o_saturated !== want.saturated)
                        report_mismatch("saturated", o_saturated, want.saturated);
                    o_units_checked++;
                    if (want.saturated) o_sat_seen++;
                end
            end
            if (start && !busy) begin
                expected_units.push_back(compute_unit(i_pre_input_gate, i_pre_candidate,
                    i_pre_forget_gate, i_pre_output_gate, i_cell_prev, i_hidden_prev));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FORGET_BIAS: begin
                        forget_bias_q <= longint'($signed(i_cfg_data));
                    end
                    REG_ZONEOUT_CELL: begin
                        zone_cell_w <= longint'(i_cfg_data[12:0]);
                    end
                    REG_ZONEOUT_HIDDEN: begin
                        zone_hidden_w <= longint'(i_cfg_data[12:0]);
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending <= expected_units.size();
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    import lcp_pkg::*;

    localparam int LATENCY = 16;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;
    logic signed [15:0] i_pre_input_gate;
    logic signed [15:0] i_pre_candidate;
    logic signed [15:0] i_pre_forget_gate;
    logic signed [15:0] i_pre_output_gate;
    logic signed [15:0] i_cell_prev;
    logic signed [15:0] i_hidden_prev;
    logic               o_valid;
    logic signed [15:0] o_cell_next;
    logic signed [15:0] o_hidden_out;
    logic signed [15:0] o_hidden_keep;
    logic               o_saturated;
    int                 mismatches;
    int                 units_checked;
    int                 sat_seen;
    int                 pending;
    int                 units_sent;

    lstm_cell_pointwise u_top (.*);

    lstm_cell_checker u_checker (
        .*,
        .o_errors(mismatches),
        .o_units_checked(units_checked),
        .o_sat_seen(sat_seen),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Timeout with %0d results outstanding.", pending);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [15:0] pick_value(int mode);
        case (mode)
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($signed($urandom_range(0, 16384)) - 8192);
            3: return 16'($signed($urandom_range(0, 65536)) - 32768);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_unit(logic [15:0] pi, logic [15:0] pg, logic [15:0] pf,
                             logic [15:0] po, logic [15:0] cp, logic [15:0] hp,
                             bit allow_gap);
        while (allow_gap && $urandom_range(0, 99) < 13) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_pre_input_gate <= pi;
        i_pre_candidate <= pg;
        i_pre_forget_gate <= pf;
        i_pre_output_gate <= po;
        i_cell_prev <= cp;
        i_hidden_prev <= hp;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        units_sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_units(int count, bit gaps);
        int m;
        for (int n = 0; n < count; n++) begin
            m = $urandom_range(0, 9);
            send_unit(pick_value(m < 1 ? 0 : m < 2 ? 1 : m < 6 ? 2 : 4),
                      pick_value($urandom_range(0, 5)), pick_value($urandom_range(1, 5)),
                      pick_value($urandom_range(2, 5)), pick_value($urandom_range(0, 5)),
                      pick_value($urandom_range(0, 5)), gaps);
        end
    endtask

    initial begin
        logic [15:0] corner[6];
        units_sent = 0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_FORGET_BIAS;
        i_cfg_data = '0;
        i_pre_input_gate = '0;
        i_pre_candidate = '0;
        i_pre_forget_gate = '0;
        i_pre_output_gate = '0;
        i_cell_prev = '0;
        i_hidden_prev = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        corner = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh1000, 16'shf000, 16'sh0001};
        for (int k = 0; k < 6; k++) begin
            send_unit(corner[k], corner[k], corner[k], corner[k], corner[k], corner[k], 0);
        end
        send_unit(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 0);
        send_unit(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 0);
        send_unit(16'sh0800, 16'sh2000, 16'shf800, 16'sh0400, 16'sh3000, 16'shd000, 0);
        send_unit(16'sh0000, 16'sh0000, 16'sh0000, 16'sh7fff, 16'sh0000, 16'sh0000, 1);
        write_reg(REG_FORGET_BIAS, 16'sh7fff);
        write_reg(REG_ZONEOUT_CELL, 16'd4096);
        write_reg(REG_ZONEOUT_HIDDEN, 16'd8191);
        send_unit(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 0);
        send_unit(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 0);
        send_unit(16'sh1000, 16'sh1000, 16'sh1000, 16'sh1000, 16'sh1000, 16'sh1000, 0);
        write_reg(REG_UNUSED, 16'hffff);
        write_reg(REG_FORGET_BIAS, 16'sh8000);
        send_unit(16'sh1000, 16'sh1000, 16'sh7fff, 16'sh1000, 16'sh7000, 16'sh1000, 0);
        random_units(20, 1);

        for (int phase = 0; phase < 8; phase++) begin
            write_reg(REG_FORGET_BIAS, phase == 1 ? 16'sh7fff : phase == 2 ? 16'sh8000 :
                      pick_value($urandom_range(2, 4)));
            write_reg(REG_ZONEOUT_CELL, phase < 2 ? 16'd0 : phase == 3 ? 16'd4096 :
                      phase == 4 ? 16'd8191 : 16'($urandom_range(0, 4096)));
            write_reg(REG_ZONEOUT_HIDDEN, phase < 2 ? 16'd0 : phase == 3 ? 16'd4096 :
                      phase == 5 ? 16'd8191 : 16'($urandom_range(0, 8191)));
            random_units(215, phase != 6);
        end

        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        $display("Sent %0d units through eight register settings and checked %0d results.",
                 units_sent, units_checked);
        $display("%0d results carried the saturation flag.", sat_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
